[hdl/pfts_pkg.sv]
// Shared types and constants for the periodic frame transmit scheduler.
// No dependencies.
package pfts_pkg;
	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_SEEN   = 2'd1;
	localparam logic [1:0] CMD_TICK   = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [1:0] REG_MASK  = 2'd0;
	localparam logic [1:0] REG_BURST = 2'd1;
	localparam logic [1:0] REG_COUNT = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_SEEN,
		ST_READ,
		ST_EVAL,
		ST_EMIT,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // write entry from input request
		logic capture;   // latch request fields
		logic idx_clear; // walk index to zero
		logic idx_next;  // walk index + 1
		logic init_wr;   // write start due time / count at walk index
		logic seen_set;  // set suppress at walk index
		logic scan_start;// origin -> scan index, clear sent count
		logic reduce;    // scan index - scan length
		logic rd;        // read entry at scan index
		logic emit;      // load holding register, update entry
		logic finish;    // settle scan origin, flush holding register
		logic started;   // mark schedule started
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic walk_end;   // walk index reached scan length
		logic id_match;   // entry at walk index matches captured id
		logic eligible;   // read entry is due and enabled
		logic scan_end;   // examined all slots
		logic limit_hit;  // sent count reached limit
		logic out_busy;   // output register holds a stalled result
		logic started;    // schedule started flag
		logic zero_limit; // limit is zero
		logic idx_high;   // scan index at or past scan length
	} sts_t;
endpackage

[hdl/pfts_ctrl.sv]
// Controller state machine for the scheduler.
// Depends on pfts_pkg.
module pfts_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [1:0]      in_cmd,
	input  pfts_pkg::sts_t  sts,
	output logic            in_stall,
	output pfts_pkg::ctl_t  ctl
);
	import pfts_pkg::*;

	state_t state_q, state_d;
	logic take;

	assign in_stall = (state_q != ST_IDLE);
	assign take = in_valid && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					if (in_cmd == CMD_SEEN) state_d = ST_SEEN;
					else if (in_cmd == CMD_TICK) state_d = sts.started ? ST_READ : ST_INIT;
				end
			end
			ST_INIT: if (sts.walk_end) state_d = ST_READ;
			ST_SEEN: if (sts.walk_end || sts.id_match) state_d = ST_IDLE;
			ST_READ: begin
				if (sts.idx_high) state_d = ST_READ;
				else if (sts.zero_limit || sts.scan_end || sts.limit_hit) state_d = ST_DONE;
				else state_d = ST_EVAL;
			end
			ST_EVAL: state_d = sts.eligible ? ST_EMIT : ST_READ;
			ST_EMIT: if (!sts.out_busy) state_d = ST_READ;
			ST_DONE: if (!sts.out_busy) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		case (state_q)
			ST_IDLE: begin
				ctl.capture = take;
				ctl.idx_clear = take;
				ctl.load = take && (in_cmd == CMD_LOAD);
				ctl.scan_start = take && (in_cmd == CMD_TICK);
			end
			ST_INIT: begin
				ctl.init_wr = !sts.walk_end;
				ctl.idx_next = !sts.walk_end;
				ctl.started = sts.walk_end;
			end
			ST_SEEN: begin
				ctl.seen_set = !sts.walk_end && sts.id_match;
				ctl.idx_next = !sts.walk_end;
			end
			ST_READ: begin
				ctl.reduce = sts.idx_high;
				ctl.rd = !sts.idx_high &&
					!(sts.zero_limit || sts.scan_end || sts.limit_hit);
			end
			ST_EVAL: ;
			ST_EMIT: ctl.emit = !sts.out_busy;
			ST_DONE: ctl.finish = !sts.out_busy;
			default: ;
		endcase
	end
endmodule

[hdl/pfts_dp.sv]
// Datapath: entry tables, walk and scan counters, output register.
// Depends on pfts_pkg.
module pfts_dp #(
	parameter int TABLE_DEPTH = 32,
	parameter int BURST_LIMIT = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  pfts_pkg::ctl_t  ctl,
	output pfts_pkg::sts_t  sts,
	input  logic [4:0]      entry_index,
	input  logic [10:0]     frame_id,
	input  logic [15:0]     repeat_period,
	input  logic [15:0]     first_offset,
	input  logic [3:0]      group_number,
	input  logic            counter_enable,
	input  logic [7:0]      initial_count,
	input  logic [31:0]     now_ms,
	input  logic [15:0]     mask,
	input  logic [4:0]      max_per_tick,
	input  logic [5:0]      entries_in_use,
	input  logic            out_stall,
	output logic            out_valid,
	output logic [4:0]      slot,
	output logic [10:0]     send_id,
	output logic [7:0]      alive_value,
	output logic            alive_valid,
	output logic            last
);
	import pfts_pkg::*;

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int LW = 5;

	// static entry fields, packed: id, period, offset, group, ce, start
	localparam int EW = 11 + 16 + 16 + 4 + 1 + 8;
	logic [EW-1:0] ent_mem [TABLE_DEPTH];
	logic [31:0]   due_mem [TABLE_DEPTH];
	logic [7:0]    cnt_mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] supp_q;

	logic [10:0] id_q;
	logic [31:0] now_q;
	logic [CW-1:0] walk_q, n;
	logic [CW-1:0] k_q;     // slots examined
	logic [IW-1:0] idx_q, orig_q, last_idx_q;
	logic [LW-1:0] sent_q, limit;
	logic started_q;

	logic [EW-1:0] ent_s1;
	logic [31:0]   due_s1;
	logic [7:0]    cnt_s1;
	logic          supp_s1;
	logic [IW-1:0] ridx_s1;

	logic [10:0] r_id; logic [15:0] r_per; logic [3:0] r_grp;
	logic r_ce;
	logic [31:0] due_adv, diff;
	logic [IW-1:0] walk_idx;

	// holding register: a frame waits here until the next frame or the end
	// of the scan tells whether it is the last one of the tick
	logic          hold_vld_q;
	logic [4:0]    hold_slot_q;
	logic [10:0]   hold_id_q;
	logic [7:0]    hold_av_q;
	logic          hold_avl_q;
	logic          last_q;
	logic          out_load;

	assign n = (int'(entries_in_use) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(entries_in_use);
	always_comb begin
		limit = max_per_tick;
		if (int'(limit) > BURST_LIMIT) limit = LW'(BURST_LIMIT);
		if (limit > 5'd16) limit = 5'd16;
	end
	assign walk_idx = walk_q[IW-1:0];
	assign r_id  = ent_s1[EW-1 -: 11];
	assign r_per = ent_s1[EW-12 -: 16];
	assign r_grp = ent_s1[12:9];
	assign r_ce  = ent_s1[8];
	assign out_load = (ctl.emit || ctl.finish) && hold_vld_q;

	// tables: one write port each
	always_ff @(posedge clk) begin
		if (ctl.load && (32'(entry_index) < TABLE_DEPTH))
			ent_mem[IW'(entry_index)] <= {frame_id, repeat_period, first_offset, group_number,
				counter_enable, initial_count};
		if (ctl.init_wr) begin
			due_mem[walk_idx] <= now_q + 32'(ent_mem[walk_idx][EW-28 -: 16]);
			cnt_mem[walk_idx] <= ent_mem[walk_idx][7:0];
		end else if (ctl.emit) begin
			due_mem[ridx_s1] <= ((now_q - due_adv) < 32'h8000_0000 &&
				(now_q - due_adv) >= 32'(r_per)) ? now_q + 32'(r_per) : due_adv;
			cnt_mem[ridx_s1] <= cnt_s1 + 8'd1;
		end
		if (ctl.rd) begin
			ent_s1 <= ent_mem[idx_q];
			due_s1 <= due_mem[idx_q];
			cnt_s1 <= cnt_mem[idx_q];
			supp_s1 <= supp_q[idx_q];
			ridx_s1 <= idx_q;
		end
		if (ctl.capture) begin
			id_q <= frame_id;
			now_q <= now_ms;
		end
	end

	assign due_adv = due_s1 + 32'(r_per);
	assign diff = now_q - due_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			supp_q <= '0;
			started_q <= 1'b0;
			orig_q <= '0;
			walk_q <= '0;
			k_q <= '0;
			idx_q <= '0;
			sent_q <= '0;
			last_idx_q <= '0;
			hold_vld_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (ctl.load && (32'(entry_index) < TABLE_DEPTH)) started_q <= 1'b0;
			if (ctl.started) started_q <= 1'b1;
			if (ctl.seen_set) supp_q[walk_idx] <= 1'b1;
			if (ctl.idx_clear) walk_q <= '0;
			else if (ctl.idx_next) walk_q <= walk_q + 1'b1;
			if (ctl.scan_start) begin
				idx_q <= orig_q;
				k_q <= '0;
				sent_q <= '0;
				last_idx_q <= orig_q;
			end
			// origin left past a shrunken scan length: fold it back one step a cycle
			if (ctl.reduce) begin
				idx_q <= IW'(CW'(idx_q) - n);
			end else if (ctl.rd) begin
				k_q <= k_q + 1'b1;
				last_idx_q <= idx_q;
				idx_q <= (CW'(idx_q) + 1'b1 >= n) ? '0 : idx_q + 1'b1;
			end
			if (ctl.emit) sent_q <= sent_q + 1'b1;
			if (ctl.finish) begin
				if (n == '0) orig_q <= '0;
				else if (sent_q >= limit) begin
					if (limit == '0) orig_q <= (CW'(idx_q) + 1'b1 >= n) ? '0 : idx_q + 1'b1;
					else orig_q <= (CW'(last_idx_q) + 1'b1 >= n) ? '0 : last_idx_q + 1'b1;
				end else orig_q <= '0;
			end
			if (ctl.emit) hold_vld_q <= 1'b1;
			else if (ctl.finish) hold_vld_q <= 1'b0;
			if (out_load) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
		end
	end

	// last flag: only the frame flushed at the end of the scan carries it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) last_q <= 1'b0;
		else if (out_load) last_q <= ctl.finish;
	end
	assign last = last_q;

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			hold_slot_q <= 5'(ridx_s1);
			hold_id_q <= r_id;
			hold_av_q <= r_ce ? cnt_s1 : 8'd0;
			hold_avl_q <= r_ce;
		end
		if (out_load) begin
			slot <= hold_slot_q;
			send_id <= hold_id_q;
			alive_value <= hold_av_q;
			alive_valid <= hold_avl_q;
		end
	end

	assign sts.walk_end = (walk_q >= n);
	assign sts.id_match = (ent_mem[walk_idx][EW-1 -: 11] == id_q);
	assign sts.eligible = !supp_s1 && mask[r_grp] && !diff[31];
	assign sts.scan_end = (k_q >= n);
	assign sts.limit_hit = (sent_q >= limit);
	assign sts.out_busy = out_valid && out_stall;
	assign sts.started = started_q;
	assign sts.zero_limit = (limit == '0);
	assign sts.idx_high = (n != '0) && (CW'(idx_q) >= n);
endmodule

[hdl/periodic_frame_tx_scheduler_core.sv]
// Top level: APB registers, controller and datapath of the scheduler.
// Depends on pfts_pkg, pfts_ctrl, pfts_dp.
//
// channel | direction | handshake           | payload
// in      | input     | in_valid/in_stall   | cmd .. now_ms
// out     | output    | out_valid/out_stall | slot .. last
// cfg     | input     | APB psel/penable    | group mask, burst, entries
//
// A load writes its entry when accepted; a bus-seen request walks the table
// up to the first matching id. A tick first sets start due times and counts
// after a reload, and folds the scan origin back in range after entries in
// use shrinks; then it reads and evaluates each slot, emits due frames, closes.
// Reset clears control state and the suppress flags; tables are undefined.
// Frames trail the scan by one in a holding register so the last flag is
// known; a stalled result holds the scan, and the tick ends once it is free.
module periodic_frame_tx_scheduler_core #(
	parameter int TABLE_DEPTH = 32,
	parameter int BURST_LIMIT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [4:0]  entry_index,
	input  logic [10:0] frame_id,
	input  logic [15:0] repeat_period,
	input  logic [15:0] first_offset,
	input  logic [3:0]  group_number,
	input  logic        counter_enable,
	input  logic [7:0]  initial_count,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  slot,
	output logic [10:0] send_id,
	output logic [7:0]  alive_value,
	output logic        alive_valid,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import pfts_pkg::*;

	ctl_t ctl;
	sts_t sts;
	logic [15:0] mask_q;
	logic [4:0]  burst_q;
	logic [5:0]  count_q;
	logic [1:0]  reg_idx;

	assign pready = 1'b1;
	assign reg_idx = paddr[3:2];

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= 16'hFFFF;
			burst_q <= 5'd4;
			count_q <= 6'd0;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			case (reg_idx)
				REG_MASK:  mask_q <= pwdata[15:0];
				REG_BURST: burst_q <= pwdata[4:0];
				REG_COUNT: count_q <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MASK:  prdata = {16'd0, mask_q};
			REG_BURST: prdata = {27'd0, burst_q};
			REG_COUNT: prdata = {26'd0, count_q};
			default:   prdata = 32'd0;
		endcase
	end

	pfts_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_cmd(cmd), .sts, .in_stall, .ctl
	);

	pfts_dp #(.TABLE_DEPTH(TABLE_DEPTH), .BURST_LIMIT(BURST_LIMIT)) u_dp (
		.clk, .arst_n, .ctl, .sts,
		.entry_index, .frame_id, .repeat_period, .first_offset, .group_number,
		.counter_enable, .initial_count, .now_ms,
		.mask(mask_q), .max_per_tick(burst_q), .entries_in_use(count_q),
		.out_stall, .out_valid, .slot, .send_id, .alive_value, .alive_valid, .last
	);

	// a result is never dropped: new one only when the register is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.emit || ctl.finish) |-> !(out_valid && out_stall))
		else $error("result overwritten");
	// loads never overlap a scan
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |-> !in_stall) else $error("load while busy");
	// a result only appears after a frame was emitted or flushed
	a_emit_elig: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(ctl.emit || ctl.finish)) else $error("spurious result");
endmodule

[dv/pfts_checker.sv]
// Checker for the periodic frame transmit scheduler: watches the request,
// result and register channels, predicts frames and compares them.
// Depends on pfts_pkg.
`timescale 1ns / 100ps
module pfts_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [4:0]  entry_index,
	input  logic [10:0] frame_id,
	input  logic [15:0] repeat_period,
	input  logic [15:0] first_offset,
	input  logic [3:0]  group_number,
	input  logic        counter_enable,
	input  logic [7:0]  initial_count,
	input  logic [31:0] now_ms,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [4:0]  slot,
	input  logic [10:0] send_id,
	input  logic [7:0]  alive_value,
	input  logic        alive_valid,
	input  logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fails,
	output int          pending
);
	import pfts_pkg::*;

	typedef struct packed {
		logic [4:0]  slot;
		logic [10:0] send_id;
		logic [7:0]  alive_value;
		logic        alive_valid;
		logic        last;
	} frame_t;

	frame_t frame_q[$];

	logic [15:0] grp_mask;
	logic [4:0]  burst;
	logic [5:0]  n_entries;
	logic [10:0] ids[32];
	logic [15:0] periods[32];
	logic [15:0] offsets[32];
	logic [3:0]  groups[32];
	logic        cnt_en[32];
	logic [7:0]  cnt_init[32];
	logic [31:0] due[32];
	logic [7:0]  alive[32];
	logic        supp[32];
	logic        sched_on;
	int          origin;

	assign pending = frame_q.size();

	function automatic int scan_len();
		return (n_entries < 32) ? int'(n_entries) : 32;
	endfunction

	// one tick: emit due frames, advance due times
	task automatic schedule_tick(input logic [31:0] now);
		int n, lim, sent, idx;
		logic [31:0] d;
		frame_t burst_q[$];
		frame_t f;
		n = scan_len();
		lim = (burst > 16) ? 16 : int'(burst);
		sent = 0;
		idx = origin;
		if (!sched_on) begin
			for (int k = 0; k < n; k++) begin
				due[k] = now + 32'(offsets[k]);
				alive[k] = cnt_init[k];
			end
			sched_on = 1'b1;
		end
		for (int k = 0; k < n && sent < lim; k++) begin
			idx = (origin + k) % n;
			if (supp[idx] || !grp_mask[groups[idx]])
				continue;
			d = now - due[idx];
			if (d[31])
				continue;
			f.slot = 5'(idx);
			f.send_id = ids[idx];
			f.alive_valid = cnt_en[idx];
			f.alive_value = cnt_en[idx] ? alive[idx] : 8'd0;
			f.last = 1'b0;
			if (cnt_en[idx])
				alive[idx] = alive[idx] + 8'd1;
			burst_q.push_back(f);
			sent++;
			due[idx] = due[idx] + 32'(periods[idx]);
			d = now - due[idx];
			if (!d[31] && d >= 32'(periods[idx]))
				due[idx] = now + 32'(periods[idx]);
		end
		if (n == 0)
			origin = 0;
		else if (sent >= lim)
			origin = (idx + 1) % n;
		else
			origin = 0;
		if (sent > 0)
			burst_q[sent-1].last = 1'b1;
		foreach (burst_q[i])
			frame_q.push_back(burst_q[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_t got, exp_f;
		if (!arst_n) begin
			grp_mask = 16'hFFFF;
			burst = 5'd4;
			n_entries = 6'd0;
			sched_on = 1'b0;
			origin = 0;
			foreach (supp[i])
				supp[i] = 1'b0;
			frame_q.delete();
			fails = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = '{slot, send_id, alive_value, alive_valid, last};
				if (frame_q.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected frame: slot %0d id %h", slot, send_id);
				end else begin
					exp_f = frame_q.pop_front();
					if (got !== exp_f) begin
						fails++;
						if (fails <= 10)
							$display("frame mismatch: exp %0d/%h/%h/%b/%b got %0d/%h/%h/%b/%b",
								exp_f.slot, exp_f.send_id, exp_f.alive_value,
								exp_f.alive_valid, exp_f.last, got.slot, got.send_id,
								got.alive_value, got.alive_valid, got.last);
					end
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_MASK:  grp_mask = pwdata[15:0];
					REG_BURST: burst = pwdata[4:0];
					REG_COUNT: n_entries = pwdata[5:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				case (cmd)
					CMD_LOAD: begin
						ids[entry_index] = frame_id;
						periods[entry_index] = repeat_period;
						offsets[entry_index] = first_offset;
						groups[entry_index] = group_number;
						cnt_en[entry_index] = counter_enable;
						cnt_init[entry_index] = initial_count;
						sched_on = 1'b0;
					end
					CMD_SEEN: begin
						for (int k = 0; k < scan_len(); k++)
							if (ids[k] == frame_id) begin
								supp[k] = 1'b1;
								break;
							end
					end
					CMD_TICK: schedule_tick(now_ms);
					default: ;
				endcase
			end
		end
	end
endmodule

[dv/tb_periodic_frame_tx_scheduler_core.sv]
// Testbench top for the periodic frame transmit scheduler: clock, reset,
// request and register stimulus, result stall, verdict.
// Depends on pfts_pkg, periodic_frame_tx_scheduler_core, pfts_checker.
`timescale 1ns / 100ps
module tb_periodic_frame_tx_scheduler_core;
	import pfts_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  cmd = CMD_TICK;
	logic [4:0]  entry_index = '0;
	logic [10:0] frame_id = '0;
	logic [15:0] repeat_period = '0;
	logic [15:0] first_offset = '0;
	logic [3:0]  group_number = '0;
	logic        counter_enable = 1'b0;
	logic [7:0]  initial_count = '0;
	logic [31:0] now_ms = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [4:0]  slot;
	logic [10:0] send_id;
	logic [7:0]  alive_value;
	logic        alive_valid;
	logic        last;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int          fails;
	int          pending;
	int          cycles = 0;
	bit          calm = 1'b0;     // no idling on either side
	bit          hold_req = 1'b0; // ask the result side for one long hold-off
	logic [31:0] tnow = 32'd1000;
	logic [10:0] slot_ids[32];   // ids loaded so far, to aim bus-seen requests

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	periodic_frame_tx_scheduler_core dut (.*);

	pfts_checker chk (.*);

	// runaway guard
	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// result side: random stall bursts, one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// offer one request and hold it until taken; valid stays up between back-to-back requests
	task automatic send_req(input logic [1:0] c, input logic [4:0] ix, input logic [10:0] id,
			input logic [15:0] per, input logic [15:0] off, input logic [3:0] grp,
			input logic ce, input logic [7:0] ic, input logic [31:0] now);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		entry_index <= ix;
		frame_id <= id;
		repeat_period <= per;
		first_offset <= off;
		group_number <= grp;
		counter_enable <= ce;
		initial_count <= ic;
		now_ms <= now;
		if (c == CMD_LOAD)
			slot_ids[ix] = id;
		do
			@(negedge clk);
		while (in_stall);
		@(posedge clk);
	endtask

	task automatic go_idle();
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic load_slot(input logic [4:0] ix);
		send_req(CMD_LOAD, ix, 11'($urandom), 16'($urandom_range(0, 40)),
			16'($urandom_range(0, 30)), 4'($urandom), 1'($urandom), 8'($urandom), '0);
	endtask

	task automatic tick(input logic [31:0] dt);
		tnow = tnow + dt;
		send_req(CMD_TICK, 5'($urandom), 11'($urandom), 16'($urandom), 16'($urandom),
			4'($urandom), 1'($urandom), 8'($urandom), tnow);
	endtask

	// random request: mostly ticks, some reloads, rare bus-seen and unused codes
	task automatic random_req();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			tick((r < 3) ? $urandom : $urandom_range(0, 40));
		else if (r < 88)
			load_slot(5'($urandom));
		else if (r < 90)
			send_req(CMD_SEEN, '0, slot_ids[5'($urandom)], '0, '0, '0, 1'b0, '0, '0);
		else if (r < 92)
			send_req(CMD_SEEN, '0, 11'($urandom), '0, '0, '0, 1'b0, '0, '0);
		else if (r < 94)
			send_req(CMD_UNUSED, 5'($urandom), 11'($urandom), 16'($urandom), 16'($urandom),
				4'($urandom), 1'($urandom), 8'($urandom), $urandom);
		else if (r < 97)
			send_req(CMD_LOAD, 5'($urandom), 11'($urandom), 16'($urandom), 16'($urandom),
				4'($urandom), 1'($urandom), 8'($urandom), '0);
		else
			tick(32'($urandom_range(0, 2)));
	endtask

	initial begin
		logic [15:0] masks[6];
		logic [4:0]  bursts[6];
		logic [5:0]  counts[6];
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// field extremes in the first slots, then fill the rest of the table
		send_req(CMD_LOAD, 5'd0, 11'd0, 16'd1, 16'd0, 4'd0, 1'b1, 8'd255, '0);
		send_req(CMD_LOAD, 5'd1, 11'h7FF, 16'hFFFF, 16'hFFFF, 4'd15, 1'b0, 8'd0, '0);
		send_req(CMD_LOAD, 5'd2, 11'h155, 16'd0, 16'd3, 4'd5, 1'b1, 8'd254, '0); // zero period
		send_req(CMD_LOAD, 5'd3, 11'h2AA, 16'd2, 16'd1, 4'd10, 1'b1, 8'h0F, '0);
		for (int i = 4; i < 32; i++)
			load_slot(5'(i));
		go_idle();
		// whole table scanned so every due time and count gets a start value
		reg_write(REG_COUNT, 32'd32);
		go_idle();
		tick(0);
		tick(0);
		tick(1);
		tick(32'hFFFF_FFF0);  // due test across the wrap
		tick(32'h20);
		send_req(CMD_UNUSED, 5'd31, 11'h7FF, 16'hFFFF, 16'hFFFF, 4'd15, 1'b1, 8'hFF,
			32'hFFFF_FFFF);
		send_req(CMD_SEEN, '0, 11'h2AA, '0, '0, '0, 1'b0, '0, '0);
		tick(70000);          // far behind: resync
		tick(5);

		masks  = '{16'hFFFF, 16'h0000, 16'hA5A5, 16'hFFFF, 16'h5A5A, 16'hFFFF};
		bursts = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd3, 5'd4};
		counts = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd17, 6'd32};
		for (int p = 0; p < 6; p++) begin
			go_idle();
			reg_write(REG_MASK, 32'({$urandom, masks[p]} >> 16));
			reg_write(REG_MASK, {16'($urandom), masks[p]});
			reg_write(REG_BURST, {27'($urandom), bursts[p]});
			reg_write(REG_COUNT, {26'($urandom), counts[p]});
			if (p == 5)
				calm = 1'b1;
			for (int i = 0; i < 32; i++) begin
				if (p == 0 && i == 10)
					hold_req = 1'b1;
				if (p == 3 && i == 16) begin
					in_valid <= 1'b0;
					while (pending != 0)
						@(posedge clk);
				end
				random_req();
			end
		end

		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

[sim.f]
hdl/pfts_pkg.sv
hdl/pfts_ctrl.sv
hdl/pfts_dp.sv
hdl/periodic_frame_tx_scheduler_core.sv
dv/pfts_checker.sv
dv/tb_periodic_frame_tx_scheduler_core.sv
